[src/imrs_pkg.sv]
// shared constants, types and helpers for the image resampler core
// no dependencies; compiled first
package imrs_pkg;

   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int PIXEL_BITS   = 8;
   localparam int SIZE_BITS    = 9;
   localparam int MODE_BITS    = 2;
   localparam int OPCODE_BITS  = 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int COORD_BITS   = 8;
   localparam int SRC_BITS     = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int FRAME_BITS   = ADDR_BITS + 1;
   localparam int NUM_BITS     = COORD_BITS + SRC_BITS;
   localparam int TAP_BITS     = 4;
   localparam int OFFSET_BITS  = 2;
   localparam int SUM_BITS     = PIXEL_BITS + TAP_BITS;
   localparam int MIN_SRC_SIZE = 2;
   localparam int MIN_OUT_SIZE = 1;

   typedef logic [SIZE_BITS-1:0]      size_type;
   typedef logic [MODE_BITS-1:0]      mode_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [OPCODE_BITS-1:0]    opcode_type;

   // operation codes
   localparam opcode_type OP_LOAD = 1'b0;
   localparam opcode_type OP_EMIT = 1'b1;

   // register indexes
   localparam csr_index_type REG_SRC_WIDTH  = 3'd0;
   localparam csr_index_type REG_SRC_HEIGHT = 3'd1;
   localparam csr_index_type REG_OUT_WIDTH  = 3'd2;
   localparam csr_index_type REG_OUT_HEIGHT = 3'd3;
   localparam csr_index_type REG_MODE       = 3'd4;

   // resample modes
   localparam mode_type MODE_NEAREST = 2'd0;
   localparam mode_type MODE_MEAN2   = 2'd1;
   localparam mode_type MODE_MEAN4   = 2'd2;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] dividend;
      logic [SRC_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [NUM_BITS-1:0] quotient;
   } div_rsp_type;

   function automatic size_type clamp_size(input size_type v, input size_type lo,
                                           input size_type hi);
      size_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[src/imrs_if.sv]
// valid/ready channel interfaces: request, response and register write
// depends on imrs_pkg
interface imrs_req_if;
   import imrs_pkg::*;
   logic                  valid;
   logic                  ready;
   opcode_type            opcode;
   logic [PIXEL_BITS-1:0] pixel_in;
   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface imrs_rsp_if;
   import imrs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  frame_last;
   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface imrs_csr_if;
   import imrs_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   size_type      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/imrs_ram.sv]
// generic single-port ram with registered read data
// no dependencies
module imrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/imrs_divider.sv]
// shared restoring divider, one quotient bit per cycle
// depends on imrs_pkg
module imrs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  imrs_pkg::div_req_type div_req,
   output imrs_pkg::div_rsp_type div_rsp
);
   import imrs_pkg::*;

   localparam int STEP_BITS = $clog2(NUM_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [NUM_BITS-1:0]  quo_ff, quo_in;
   logic [SRC_BITS-1:0]  rem_ff, rem_in;
   logic [SRC_BITS-1:0]  divisor_ff, divisor_in;
   logic [SRC_BITS:0]    trial;
   logic [SRC_BITS:0]    diff;

   always_comb begin
      trial      = {rem_ff, quo_ff[NUM_BITS-1]};
      diff       = trial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so trial fits after subtracting
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[SRC_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SRC_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[src/image_resampler_box_average_core.sv]
// Greyscale image resizer. A load transaction writes the next source pixel of a 256x256 frame
// store in raster order; the block takes another load in the next cycle. An emit transaction
// returns the next output pixel in raster order, either the nearest source pixel or the
// truncated mean of the 2x2 or 4x4 block starting there. For an emit, the source row and column
// each go through one shared 16-step restoring divider, and each tap of an averaged pixel is one
// read of the single-port frame store. An output size of 1 skips that division. There is no
// clearing pass after reset; read only pixels that were loaded. Register writes are taken at any
// time.
// depends on imrs_pkg, imrs_if, imrs_ram, imrs_divider
module image_resampler_box_average_core (
   input logic       clock,
   input logic       reset,
   imrs_req_if.sink  req_bus,
   imrs_rsp_if.source rsp_bus,
   imrs_csr_if.sink  csr_bus
);
   import imrs_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ROW      = 3'd1;
   localparam logic [2:0] S_ROW_WAIT = 3'd2;
   localparam logic [2:0] S_COL      = 3'd3;
   localparam logic [2:0] S_COL_WAIT = 3'd4;
   localparam logic [2:0] S_READ     = 3'd5;
   localparam logic [2:0] S_DRAIN    = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   localparam size_type SIZE_ONE    = SIZE_BITS'(1);
   localparam size_type SRC_MIN     = SIZE_BITS'(MIN_SRC_SIZE);
   localparam size_type OUT_MIN     = SIZE_BITS'(MIN_OUT_SIZE);
   localparam size_type WIDTH_MAX   = SIZE_BITS'(MAX_WIDTH);
   localparam size_type HEIGHT_MAX  = SIZE_BITS'(MAX_HEIGHT);
   localparam int       ADDR_FULL_BITS = SRC_BITS + SIZE_BITS;

   // clamped size registers
   size_type src_width_ff, src_width_in;
   size_type src_height_ff, src_height_in;
   size_type out_width_ff, out_width_in;
   size_type out_height_ff, out_height_in;
   mode_type mode_ff, mode_in;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  load_addr_ff, load_addr_in;
   logic [COORD_BITS-1:0] out_row_ff, out_row_in;
   logic [COORD_BITS-1:0] out_col_ff, out_col_in;
   logic [SRC_BITS-1:0]   src_row_ff, src_row_in;
   logic [SRC_BITS-1:0]   src_col_ff, src_col_in;
   logic [TAP_BITS-1:0]   tap_ff, tap_in;
   logic [ADDR_BITS-1:0]  read_addr_ff, read_addr_in;
   logic                  addr_valid_ff, addr_valid_in;
   logic                  data_valid_ff, data_valid_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] pixel_out_ff, pixel_out_in;
   logic                  frame_last_ff, frame_last_in;

   logic [2*SIZE_BITS-1:0]     frame_full;
   logic [FRAME_BITS-1:0]      frame;
   logic [ADDR_BITS-1:0]       load_base;
   logic [FRAME_BITS-1:0]      load_next;
   logic                       req_fire, load_fire, emit_fire, csr_fire, out_free;
   size_type                   sw_m1, sh_m1, ow_m1, oh_m1;
   logic [COORD_BITS-1:0]      mul_a;
   logic [SRC_BITS-1:0]        mul_b;
   logic [NUM_BITS-1:0]        quo;
   logic [TAP_BITS-1:0]        last_tap;
   logic [OFFSET_BITS-1:0]     dr, dc;
   size_type                   row_sum, col_sum;
   logic [SRC_BITS-1:0]        rd_row, rd_col;
   logic [ADDR_FULL_BITS-1:0]  addr_full;
   logic [ADDR_BITS-1:0]       ram_addr;
   logic [PIXEL_BITS-1:0]      ram_rd_data;
   logic [PIXEL_BITS-1:0]      pix;
   logic                       last;
   size_type                   col_next, row_next;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign load_fire = req_fire && (req_bus.opcode == OP_LOAD);
   assign emit_fire = req_fire && (req_bus.opcode == OP_EMIT);
   assign csr_fire  = csr_bus.valid && csr_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign frame_full = src_width_ff * src_height_ff;
   assign frame      = frame_full[FRAME_BITS-1:0];
   assign load_base  = ({1'b0, load_addr_ff} >= frame) ? '0 : load_addr_ff;
   assign load_next  = {1'b0, load_base} + 1'b1;

   assign sw_m1 = src_width_ff - SIZE_ONE;
   assign sh_m1 = src_height_ff - SIZE_ONE;
   assign ow_m1 = out_width_ff - SIZE_ONE;
   assign oh_m1 = out_height_ff - SIZE_ONE;

   // one multiplier feeds the divider for both row and column
   assign mul_a = (state_ff == S_ROW) ? out_row_ff : out_col_ff;
   assign mul_b = (state_ff == S_ROW) ? sh_m1[SRC_BITS-1:0] : sw_m1[SRC_BITS-1:0];

   always_comb begin
      div_req.dividend = mul_a * mul_b;
      div_req.divisor  = (state_ff == S_ROW) ? oh_m1[SRC_BITS-1:0] : ow_m1[SRC_BITS-1:0];
      div_req.start    = ((state_ff == S_ROW) && (out_height_ff > SIZE_ONE)) ||
                         ((state_ff == S_COL) && (out_width_ff > SIZE_ONE));
   end

   imrs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign quo = div_rsp.quotient;

   // block offsets per tap
   always_comb begin
      case (mode_ff)
         MODE_MEAN4: begin
            last_tap = TAP_BITS'(15);
            dr       = tap_ff[3:2];
            dc       = tap_ff[1:0];
         end
         MODE_MEAN2: begin
            last_tap = TAP_BITS'(3);
            dr       = {1'b0, tap_ff[1]};
            dc       = {1'b0, tap_ff[0]};
         end
         default: begin
            last_tap = '0;
            dr       = '0;
            dc       = '0;
         end
      endcase
   end

   // offsets past the edge fall back to the base row or column
   assign row_sum   = SIZE_BITS'(src_row_ff) + SIZE_BITS'(dr);
   assign col_sum   = SIZE_BITS'(src_col_ff) + SIZE_BITS'(dc);
   assign rd_row    = (row_sum <= sh_m1) ? row_sum[SRC_BITS-1:0] : src_row_ff;
   assign rd_col    = (col_sum <= sw_m1) ? col_sum[SRC_BITS-1:0] : src_col_ff;
   assign addr_full = rd_row * src_width_ff + ADDR_FULL_BITS'(rd_col);

   assign ram_addr = (state_ff == S_IDLE) ? load_base : read_addr_ff;

   imrs_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (load_fire),
      .addr    (ram_addr),
      .wr_data (req_bus.pixel_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (mode_ff)
         MODE_MEAN4: pix = sum_ff[SUM_BITS-1 -: PIXEL_BITS];
         MODE_MEAN2: pix = sum_ff[PIXEL_BITS+1:2];
         default:    pix = sum_ff[PIXEL_BITS-1:0];
      endcase
   end

   assign last     = ({1'b0, out_row_ff} == oh_m1) && ({1'b0, out_col_ff} == ow_m1);
   assign col_next = SIZE_BITS'(out_col_ff) + SIZE_ONE;
   assign row_next = SIZE_BITS'(out_row_ff) + SIZE_ONE;

   // register writes
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      mode_in       = mode_ff;
      if (csr_fire) begin
         case (csr_bus.index)
            REG_SRC_WIDTH:  src_width_in  = clamp_size(csr_bus.data, SRC_MIN, WIDTH_MAX);
            REG_SRC_HEIGHT: src_height_in = clamp_size(csr_bus.data, SRC_MIN, HEIGHT_MAX);
            REG_OUT_WIDTH:  out_width_in  = clamp_size(csr_bus.data, OUT_MIN, WIDTH_MAX);
            REG_OUT_HEIGHT: out_height_in = clamp_size(csr_bus.data, OUT_MIN, HEIGHT_MAX);
            REG_MODE:       mode_in       = csr_bus.data[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      load_addr_in  = load_addr_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      src_row_in    = src_row_ff;
      src_col_in    = src_col_ff;
      tap_in        = tap_ff;
      read_addr_in  = read_addr_ff;
      addr_valid_in = 1'b0;
      data_valid_in = addr_valid_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      pixel_out_in  = pixel_out_ff;
      frame_last_in = frame_last_ff;

      if (data_valid_ff) begin
         sum_in = sum_ff + SUM_BITS'(ram_rd_data);
      end

      case (state_ff)
         S_IDLE: begin
            if (load_fire) begin
               load_addr_in = (load_next >= frame) ? '0 : load_next[ADDR_BITS-1:0];
            end
            if (emit_fire) begin
               tap_in   = '0;
               sum_in   = '0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (out_height_ff > SIZE_ONE) begin
               state_in = S_ROW_WAIT;
            end else begin
               src_row_in = '0;
               state_in   = S_COL;
            end
         end
         S_ROW_WAIT: begin
            if (div_rsp.done) begin
               src_row_in = (quo > NUM_BITS'(sh_m1)) ? sh_m1[SRC_BITS-1:0] : quo[SRC_BITS-1:0];
               state_in   = S_COL;
            end
         end
         S_COL: begin
            if (out_width_ff > SIZE_ONE) begin
               state_in = S_COL_WAIT;
            end else begin
               src_col_in = '0;
               state_in   = S_READ;
            end
         end
         S_COL_WAIT: begin
            if (div_rsp.done) begin
               src_col_in = (quo > NUM_BITS'(sw_m1)) ? sw_m1[SRC_BITS-1:0] : quo[SRC_BITS-1:0];
               state_in   = S_READ;
            end
         end
         S_READ: begin
            read_addr_in  = addr_full[ADDR_BITS-1:0];
            addr_valid_in = 1'b1;
            tap_in        = tap_ff + 1'b1;
            if (tap_ff == last_tap) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!addr_valid_ff && !data_valid_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               pixel_out_in  = pix;
               frame_last_in = last;
               if (col_next >= out_width_ff) begin
                  out_col_in = '0;
                  out_row_in = (row_next >= out_height_ff) ? '0 : row_next[COORD_BITS-1:0];
               end else begin
                  out_col_in = col_next[COORD_BITS-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= WIDTH_MAX;
         src_height_ff <= HEIGHT_MAX;
         out_width_ff  <= WIDTH_MAX;
         out_height_ff <= HEIGHT_MAX;
         mode_ff       <= MODE_NEAREST;
         state_ff      <= S_IDLE;
         load_addr_ff  <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         src_row_ff    <= '0;
         src_col_ff    <= '0;
         tap_ff        <= '0;
         addr_valid_ff <= 1'b0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         mode_ff       <= mode_in;
         state_ff      <= state_in;
         load_addr_ff  <= load_addr_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         src_row_ff    <= src_row_in;
         src_col_ff    <= src_col_in;
         tap_ff        <= tap_in;
         addr_valid_ff <= addr_valid_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      read_addr_ff  <= read_addr_in;
      sum_ff        <= sum_in;
      pixel_out_ff  <= pixel_out_in;
      frame_last_ff <= frame_last_in;
   end

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_out  = pixel_out_ff;
   assign rsp_bus.frame_last = frame_last_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_read_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (!addr_valid_ff && !data_valid_ff))
      else $error("result formed with frame-store reads in flight");

   a_load_wrap: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> ({1'b0, load_addr_ff} < $past(frame)))
      else $error("load address left the source frame");

   a_rsp_posted: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && out_free) |=> rsp_valid_ff)
      else $error("finished pixel not presented");
`endif

endmodule
